### sv/hbma_pkg.sv
`timescale 1ns / 1ps

package hbma_pkg;

    // Window and field sizes
    localparam int WINDOW    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int TICK_W    = 16;
    localparam int TIMEOUT_W = 16;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int STEP_W    = $clog2(SUM_W + 1);

    // Stream payload layout
    localparam int STATUS_W     = 2;
    localparam int OUT_FIELDS_W = STATUS_W + SAMPLE_W + TICK_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);

    // Input item kind (travels on tuser)
    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_HEARTBEAT = 1'b1;

    typedef enum logic [1:0] {
        LINK_NOT_CONNECTED = 2'd0,
        LINK_CONNECTED     = 2'd1,
        LINK_ACTIVE        = 2'd2,
        LINK_LOST          = 2'd3
    } t_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_REPLACE,
        S_CHECK,
        S_DIV_START,
        S_DIV,
        S_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic latch;
        logic update;
        logic replace;
        logic check;
        logic div_start;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_hb;
        logic full;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

### sv/hbma_div.sv
`timescale 1ns / 1ps

// Restoring shift-subtract divider, one quotient bit per cycle.
module hbma_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hbma_pkg::SUM_W-1:0]  i_dividend,
    input  logic [hbma_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [hbma_pkg::SUM_W-1:0]  o_quotient
);

    logic [hbma_pkg::SUM_W-1:0]  r_quot;
    logic [hbma_pkg::CNT_W-1:0]  r_rem;
    logic [hbma_pkg::CNT_W-1:0]  r_div;
    logic [hbma_pkg::STEP_W-1:0] r_steps;

    logic [hbma_pkg::CNT_W:0]    rem_sh;
    logic [hbma_pkg::CNT_W:0]    rem_sub;
    logic                        ge;
    logic [hbma_pkg::CNT_W-1:0]  n_rem;

    // One trial subtraction
    always_comb begin
        rem_sh  = {r_rem, r_quot[hbma_pkg::SUM_W-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_sub[hbma_pkg::CNT_W-1:0] : rem_sh[hbma_pkg::CNT_W-1:0];
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else if (i_start) begin
            r_steps <= hbma_pkg::STEP_W'(hbma_pkg::SUM_W);
        end else if (r_steps != '0) begin
            r_steps <= r_steps - 1'b1;
        end
    end

    // Operands; quotient bits shift in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_steps != '0) begin
            r_quot <= {r_quot[hbma_pkg::SUM_W-2:0], ge};
            r_rem  <= n_rem;
        end
    end

    assign o_done     = (r_steps == '0);
    assign o_quotient = r_quot;

endmodule

### sv/hbma_dp.sv
`timescale 1ns / 1ps

module hbma_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hbma_pkg::t_cmd                    i_cmd,
    output hbma_pkg::t_sts                    o_sts,
    input  logic [hbma_pkg::SAMPLE_W-1:0]     i_in_sample,
    input  logic                              i_in_action,
    input  logic                              i_cfg_we,
    input  logic [hbma_pkg::TIMEOUT_W-1:0]    i_cfg_wdata,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [hbma_pkg::OUT_TDATA_W-1:0]  o_out_data
);

    // Latched input item
    logic                              r_action;
    logic [hbma_pkg::SAMPLE_W-1:0]     r_sample;

    // Monitor state
    logic [hbma_pkg::TIMEOUT_W-1:0]    r_timeout;
    hbma_pkg::t_link                   r_status, n_status;
    logic [hbma_pkg::CNT_W-1:0]        r_count, n_count;
    logic [hbma_pkg::IDX_W-1:0]        r_oldest, n_oldest;
    logic [hbma_pkg::SUM_W-1:0]        r_sum, n_sum;
    logic [hbma_pkg::TICK_W-1:0]       r_tick, n_tick;

    // Sample window
    logic [hbma_pkg::SAMPLE_W-1:0]     r_mem [hbma_pkg::WINDOW];
    logic [hbma_pkg::SAMPLE_W-1:0]     r_rd;
    logic                              mem_we;
    logic [hbma_pkg::IDX_W-1:0]        mem_addr;

    // Result register
    logic                              r_out_valid;
    hbma_pkg::t_link                   r_out_status;
    logic [hbma_pkg::SAMPLE_W-1:0]     r_out_avg;
    logic [hbma_pkg::TICK_W-1:0]       r_out_tick;

    logic                              full;
    logic                              div_done;
    logic [hbma_pkg::SUM_W-1:0]        quotient;
    logic [hbma_pkg::SAMPLE_W-1:0]     avg;

    assign full = (r_count == hbma_pkg::CNT_W'(hbma_pkg::WINDOW));

    // State update
    always_comb begin
        n_status = r_status;
        n_count  = r_count;
        n_oldest = r_oldest;
        n_sum    = r_sum;
        n_tick   = r_tick;
        mem_we   = 1'b0;
        mem_addr = r_oldest;

        if (i_cmd.update) begin
            if (r_action == hbma_pkg::ACT_HEARTBEAT) begin
                n_status = hbma_pkg::LINK_ACTIVE;
                n_tick   = '0;
                // filling: append at the fill count
                if (!full) begin
                    mem_we   = 1'b1;
                    mem_addr = r_count[hbma_pkg::IDX_W-1:0];
                    n_count  = r_count + 1'b1;
                    n_sum    = r_sum + hbma_pkg::SUM_W'(r_sample);
                end
            end else if (r_tick != '1) begin
                n_tick = r_tick + 1'b1;
            end
        end

        // full window: swap the oldest sample for the new one
        if (i_cmd.replace) begin
            mem_we   = 1'b1;
            n_sum    = r_sum - hbma_pkg::SUM_W'(r_rd) + hbma_pkg::SUM_W'(r_sample);
            n_oldest = (r_oldest == hbma_pkg::IDX_W'(hbma_pkg::WINDOW - 1)) ?
                       '0 : r_oldest + 1'b1;
        end

        // timeout: active unit goes lost, window emptied
        if (i_cmd.check && (r_status == hbma_pkg::LINK_ACTIVE) && (r_tick > r_timeout)) begin
            n_status = hbma_pkg::LINK_LOST;
            n_count  = '0;
            n_oldest = '0;
            n_sum    = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= hbma_pkg::TIMEOUT_RST;
            r_status  <= hbma_pkg::LINK_NOT_CONNECTED;
            r_count   <= '0;
            r_oldest  <= '0;
            r_sum     <= '0;
            r_tick    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_status <= n_status;
            r_count  <= n_count;
            r_oldest <= n_oldest;
            r_sum    <= n_sum;
            r_tick   <= n_tick;
        end
    end

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_in_action;
            r_sample <= i_in_sample;
        end
    end

    // Window memory, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_sample;
        end
        if (i_cmd.update) begin
            r_rd <= r_mem[r_oldest];
        end
    end

    hbma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // mean never exceeds the largest sample, so the low bits hold it
    assign avg = (r_count == '0) ? '0 : quotient[hbma_pkg::SAMPLE_W-1:0];

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_avg    <= avg;
            r_out_tick   <= r_tick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(hbma_pkg::OUT_TDATA_W - hbma_pkg::OUT_FIELDS_W){1'b0}},
                          r_out_tick, r_out_avg, r_out_status};

    assign o_sts.is_hb    = (r_action == hbma_pkg::ACT_HEARTBEAT);
    assign o_sts.full     = full;
    assign o_sts.div_done = div_done;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

endmodule

### sv/hbma_ctrl.sv
`timescale 1ns / 1ps

module hbma_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  hbma_pkg::t_sts  i_sts,
    output hbma_pkg::t_cmd  o_cmd
);

    hbma_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hbma_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = hbma_pkg::S_UPDATE;
                end
            end
            hbma_pkg::S_UPDATE: begin
                n_state = (i_sts.is_hb && i_sts.full) ? hbma_pkg::S_REPLACE
                                                      : hbma_pkg::S_CHECK;
            end
            hbma_pkg::S_REPLACE:   n_state = hbma_pkg::S_CHECK;
            hbma_pkg::S_CHECK:     n_state = hbma_pkg::S_DIV_START;
            hbma_pkg::S_DIV_START: n_state = hbma_pkg::S_DIV;
            hbma_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = hbma_pkg::S_DONE;
                end
            end
            hbma_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = hbma_pkg::S_IDLE;
                end
            end
            default: n_state = hbma_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hbma_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            hbma_pkg::S_UPDATE:    o_cmd.update    = 1'b1;
            hbma_pkg::S_REPLACE:   o_cmd.replace   = 1'b1;
            hbma_pkg::S_CHECK:     o_cmd.check     = 1'b1;
            hbma_pkg::S_DIV_START: o_cmd.div_start = 1'b1;
            hbma_pkg::S_DIV:       o_cmd           = '0;
            hbma_pkg::S_DONE:      o_cmd.out_load  = !i_sts.out_busy;
            default:               o_cmd           = '0;
        endcase
    end

endmodule

### sv/heartbeat_monitor_moving_average_core.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   rate_sample[15:0]                           action (0 tick, 1 heartbeat)
// m_axis    out  link_status[1:0], average_rate[17:2],       -
//                elapsed_ticks[33:18], zero fill to 40 bits
// cfg       in   i_cfg_wdata = timeout_ticks, written when i_cfg_we is high
//
// Each item runs update, check, divide and output; a heartbeat into a full
// window adds a replace (memory read-modify-write). The mean divider is bit-serial.
// s_axis_tready is high only while no item is in work.
// The result register lets the next item in while a result waits on m_axis;
// that item then holds in its last cycle until the waiting result is taken.
// Synchronous active-low reset; timeout_ticks resets to 1000.
module heartbeat_monitor_moving_average_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hbma_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // rate_sample
    input  logic                              s_axis_tuser,  // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hbma_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // status, avg, elapsed
    input  logic                              i_cfg_we,
    input  logic [hbma_pkg::TIMEOUT_W-1:0]    i_cfg_wdata
);

    hbma_pkg::t_cmd cmd;
    hbma_pkg::t_sts sts;

    hbma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hbma_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_sample (s_axis_tdata[hbma_pkg::SAMPLE_W-1:0]),
        .i_in_action (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef ASSERT_OFF
    // a lost unit always reports an empty window
    a_lost_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == hbma_pkg::LINK_LOST))
        |-> (m_axis_tdata[17:2] == '0))
        else $error("lost status with nonzero average");

    // no heartbeat yet means nothing stored
    a_nc_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[1:0] == hbma_pkg::LINK_NOT_CONNECTED))
        |-> (m_axis_tdata[17:2] == '0))
        else $error("not-connected status with nonzero average");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");
`endif

endmodule
